// ===== rtl/nlc_pkg.sv =====
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared constants and types for the name-to-license-code block: hash and
// generator constants, the multiply-add operation select and the result
// handoff between the sequencer and the output stage.
// ----------------------------------------------------------------------------
package nlc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_BYTES = 8;
    localparam int unsigned CODE_W = CODE_BYTES * BYTE_W;

    // Running name hash: h = h * 33 + byte
    localparam logic [WORD_W-1:0] HASH_MUL = 32'd33;
    // Linear congruential generator: s = s * 214013 + 2531011
    localparam logic [WORD_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [WORD_W-1:0] LCG_ADD = 32'd2531011;

    // Multiplier select of the shared multiply-add unit
    typedef enum logic {
        OP_HASH,
        OP_LCG
    } mac_op_t;

    // Finished code word handed from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] word;
    } nlc_result_t;

endpackage

// ===== rtl/name_to_license_code.sv =====
// ----------------------------------------------------------------------------
// name_to_license_code
// Turns a name, one byte per transaction, into a 64-bit license code word.
// ----------------------------------------------------------------------------
// A name byte without the last mark is hashed as it is accepted, so such
// bytes stream at one per cycle. The byte marked last starts eleven
// more steps on the single shared 32-bit multiply-add unit (four generator
// steps, six check-hash steps, one fold step); in_ready stays low through
// them, and longer if the output register is still full. The finished
// word sits in an output register, code byte k in bits 8k+7:8k, and the
// name hash then restarts from zero for the next name. Empty names are not
// representable: every name ends with a byte marked last.
module name_to_license_code
    import nlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] name_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CODE_W-1:0] code_word
);

    nlc_result_t       result;
    logic              out_free;
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] code_word_reg;

    assign out_free = !out_valid_reg || out_ready;

    nlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .name_byte (name_byte),
        .last_byte (last_byte),
        .out_free  (out_free),
        .result    (result)
    );

    // Hold the result until the output transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            code_word_reg <= result.word;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_word = code_word_reg;

endmodule

// ===== rtl/nlc_mac.sv =====
// ----------------------------------------------------------------------------
// nlc_mac
// Shared 32-bit multiply-add unit: y = a * m + c mod 2^32, where m is the
// hash multiplier or the generator multiplier.
// ----------------------------------------------------------------------------
module nlc_mac
    import nlc_pkg::*;
(
    input  mac_op_t           op,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] c,
    output logic [WORD_W-1:0] y
);

    logic [WORD_W-1:0] mul;
    logic [WORD_W-1:0] prod;

    // Pick the multiplier constant
    always_comb
    begin
        unique case (op)
            OP_HASH: mul = HASH_MUL;
            OP_LCG:  mul = LCG_MUL;
            default: mul = HASH_MUL;
        endcase
    end

    // Multiply, keep the low word, add
    assign prod = a * mul;
    assign y    = prod + c;

endmodule

// ===== rtl/nlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// nlc_ctrl
// Sequencer and data registers: hashes name bytes, and on the last byte
// steps the generator four times, hashes the six code bytes and folds the
// check bytes into the word, all through the one shared multiply-add unit.
// ----------------------------------------------------------------------------
module nlc_ctrl
    import nlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] name_byte,
    input  logic              last_byte,
    input  logic              out_free,
    output nlc_result_t       result
);

    localparam int unsigned GEN_STEPS = 4;
    localparam int unsigned CHK_STEPS = 6;
    localparam int unsigned CNT_W     = $clog2(CHK_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_CHK,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WORD_W-1:0]  hash_reg, hash_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  code_reg [CHK_STEPS];

    mac_op_t            mac_op;
    logic [WORD_W-1:0]  mac_c;
    logic [WORD_W-1:0]  mac_y;
    logic [BYTE_W-1:0]  gen_byte;
    logic               accept;
    logic               code_we;
    logic [CNT_W-1:0]   code_idx;
    logic [BYTE_W-1:0]  code_wdata;
    logic               last_gen;
    logic [BYTE_W-1:0]  chk_lo;
    logic [BYTE_W-1:0]  chk_hi;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign gen_byte = mac_y[23:16];
    assign last_gen = (cnt_reg == CNT_W'(GEN_STEPS - 1));

    // Select the operation and addend of the shared unit
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                mac_op = OP_HASH;
                mac_c  = WORD_W'(name_byte);
            end
            ST_GEN:
            begin
                mac_op = OP_LCG;
                mac_c  = LCG_ADD;
            end
            ST_CHK:
            begin
                mac_op = OP_HASH;
                mac_c  = WORD_W'(code_reg[cnt_reg]);
            end
            default:
            begin
                mac_op = OP_HASH;
                mac_c  = '0;
            end
        endcase
    end

    nlc_mac u_mac (
        .op (mac_op),
        .a  (hash_reg),
        .c  (mac_c),
        .y  (mac_y)
    );

    // Sequence the steps
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hash_next  = hash_reg;
        xor_next   = xor_reg;
        sum_next   = sum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hash_next = mac_y;
                    cnt_next  = '0;
                    xor_next  = '0;
                    sum_next  = '0;
                    if (last_byte)
                    begin
                        state_next = ST_GEN;
                    end
                end
            end
            ST_GEN:
            begin
                xor_next = xor_reg ^ gen_byte;
                sum_next = sum_reg + gen_byte;
                if (last_gen)
                begin
                    hash_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_CHK;
                end
                else
                begin
                    hash_next = mac_y;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_CHK:
            begin
                hash_next = mac_y;
                if (cnt_reg == CNT_W'(CHK_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    hash_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            hash_reg  <= '0;
            xor_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hash_reg  <= hash_next;
            xor_reg   <= xor_next;
            sum_reg   <= sum_next;
        end
    end

    // Capture generator bytes; the last step also stores their xor and sum
    always_comb
    begin
        code_we    = (state_reg == ST_GEN);
        code_idx   = cnt_reg;
        code_wdata = gen_byte;
    end

    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_reg[code_idx] <= code_wdata;
            if (last_gen)
            begin
                code_reg[GEN_STEPS]     <= xor_reg ^ gen_byte;
                code_reg[GEN_STEPS + 1] <= sum_reg + gen_byte;
            end
        end
    end

    // Fold the check bytes into the word
    assign chk_lo = hash_reg[23:16];
    assign chk_hi = hash_reg[31:24];

    always_comb
    begin
        result.valid = (state_reg == ST_FIN) && out_free;
        for (int n = 0; n < CHK_STEPS; n++)
        begin
            result.word[n*BYTE_W +: BYTE_W] = code_reg[n] ^ chk_lo ^ chk_hi;
        end
        result.word[CHK_STEPS*BYTE_W +: BYTE_W]       = chk_lo ^ chk_hi;
        result.word[(CHK_STEPS+1)*BYTE_W +: BYTE_W]   = chk_hi;
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for name_to_license_code. Names are streamed in one
// byte per transaction and the code word after each last byte is checked
// against a built-in model of the hash, the generator and the check fold.
// A directed table covers single-byte names, zero bytes, byte extremes and
// hash wrap. Random names of mostly short length follow. Sender gaps and
// receiver stalls vary by phase, and the receiver holds off for a long
// stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb;
    import nlc_pkg::*;

    localparam int RANDOM_ITEMS    = 900;
    localparam int DIR_ROWS        = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 30;
    localparam int NAMES_PER_PHASE = 16;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // One row of the directed table; code is used only where typed is set
    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              lst;
        bit                typed;
        logic [CODE_W-1:0] code;
    } name_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] name_byte;
    logic              last_byte;
    logic              out_valid;
    logic              out_ready;
    logic [CODE_W-1:0] code_word;

    // Model state and store of pending code words
    logic [WORD_W-1:0] name_sum = '0;
    logic [CODE_W-1:0] pending_codes [$];
    logic [CODE_W-1:0] code_due;

    name_row_t dir_rows [DIR_ROWS];

    int fail_count    = 0;
    int codes_checked = 0;
    int bytes_sent    = 0;
    int names_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_seq      = 0;
    int hold_done     = 0;
    int hold_left     = 0;

    name_to_license_code dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .name_byte (name_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_word (code_word)
    );

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Running name hash: h * 33 + byte, wrapping at 32 bits
    function automatic logic [WORD_W-1:0] hash_mix(input logic [WORD_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        return (h << 5) + h + {{(WORD_W-BYTE_W){1'b0}}, b};
    endfunction

    // Build the eight code bytes from a finished name hash
    function automatic logic [CODE_W-1:0] license_code_of(input logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] chk;
        logic [BYTE_W-1:0] cb [CODE_BYTES];
        logic [CODE_W-1:0] w;
        int                k;
        seed  = h;
        cb[4] = '0;
        cb[5] = '0;
        for (k = 0; k < 4; k++)
        begin
            seed  = seed * LCG_MUL + LCG_ADD;
            cb[k] = seed[23:16];
            cb[4] = cb[4] ^ cb[k];
            cb[5] = cb[5] + cb[k];
        end
        chk = '0;
        for (k = 0; k < 6; k++)
            chk = hash_mix(chk, cb[k]);
        cb[6] = chk[23:16];
        cb[7] = chk[31:24];
        for (k = 0; k < 6; k++)
            cb[k] = cb[k] ^ cb[6];
        for (k = 0; k < 7; k++)
            cb[k] = cb[k] ^ cb[7];
        for (k = 0; k < CODE_BYTES; k++)
            w[k*BYTE_W +: BYTE_W] = cb[k];
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [CODE_W-1:0] got,
                                 input logic [CODE_W-1:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 54; stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 54; end
            default:   begin send_idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    // Offer one byte; called and returning at a falling edge, valid left high
    task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic lst,
                             input bit typed, input logic [CODE_W-1:0] code);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        name_byte <= ch;
        last_byte <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        // Advance the model on the accepted transaction
        name_sum = hash_mix(name_sum, ch);
        if (lst)
        begin
            pending_codes.push_back(typed ? code : license_code_of(name_sum));
            name_sum = '0;
            names_sent++;
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_done)
            begin
                hold_done = hold_seq;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check each code word against the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_codes.size() == 0)
                flag_mismatch("unexpected code word", code_word, '0);
            else
            begin
                code_due = pending_codes.pop_front();
                if (code_word !== code_due)
                    flag_mismatch("code_word", code_word, code_due);
                codes_checked++;
            end
        end
    end

    // Stimulus
    initial
    begin
        int         name_idx;
        int         len;
        int         k;
        int         rand_start;
        logic [7:0] ch;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        name_byte = '0;
        last_byte = 1'b0;

        // Single-byte name 0x01 seeds the generator with 1
        dir_rows = '{
            '{8'h01, 1'b1, 1'b1, 64'h62E5_6BD5_615B_C6CC},
            '{8'hFF, 1'b1, 1'b0, 64'd0},
            '{8'h00, 1'b1, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b0, 1'b0, 64'd0},
            '{8'hFF, 1'b1, 1'b0, 64'd0},
            '{8'h41, 1'b0, 1'b0, 64'd0},
            '{8'h00, 1'b0, 1'b0, 64'd0},
            '{8'h42, 1'b1, 1'b0, 64'd0},
            '{8'h80, 1'b0, 1'b0, 64'd0},
            '{8'h7F, 1'b0, 1'b0, 64'd0},
            '{8'h55, 1'b0, 1'b0, 64'd0},
            '{8'hAA, 1'b1, 1'b0, 64'd0},
            '{8'h01, 1'b1, 1'b1, 64'h62E5_6BD5_615B_C6CC}
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table, rotating the idle mode per row
        for (k = 0; k < DIR_ROWS; k++)
        begin
            set_idle_mode(idle_mode_t'(k % 4));
            send_byte(dir_rows[k].ch, dir_rows[k].lst, dir_rows[k].typed,
                      dir_rows[k].code);
        end

        // Random names, mostly short, some long enough to wrap the hash often
        rand_start = bytes_sent;
        name_idx   = 0;
        while (bytes_sent - rand_start < RANDOM_ITEMS)
        begin
            set_idle_mode(idle_mode_t'((name_idx / NAMES_PER_PHASE) % 4));
            if (name_idx == 40 || name_idx == 90)
                hold_seq++;
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
            for (k = 0; k < len; k++)
            begin
                ch = ($urandom_range(49) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
                send_byte(ch, k == len - 1, 1'b0, '0);
            end
            name_idx++;
        end
        in_valid <= 1'b0;

        // Drain, then let the block settle
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d name bytes in %0d names; checked %0d code words.",
                 bytes_sent, names_sent, codes_checked);
        $display("Covered byte extremes, zero bytes, hash wrap, idle mixes and hold-offs.");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hang guard
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
